/* hdl/rcd_pkg.sv */
package rcd_pkg;

  // Fixed field widths of the stream words.
  localparam int REGION_W    = 4;
  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Default build values for the top-level parameters.
  localparam int REGION_COUNT_DEF  = 16;
  localparam int POSITION_BITS_DEF = 16;

  // FNV-1a, 32-bit flavor.
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  // Word kinds carried on tuser.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_REGION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_END    = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [REGION_W-1:0] region;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
    logic [BYTE_W-1:0]   tail_value;
    logic                send_ok;
  } item_t;

  typedef struct packed {
    logic [REGION_W-1:0] skip_region;
    logic [CFG_W-1:0]    skip_start;
    logic [CFG_W-1:0]    skip_end;
  } cfg_t;

  // Request from the datapath to the per-region store.
  typedef struct packed {
    logic                pass_done;
    logic                commit;
    logic [REGION_W-1:0] region;
    logic [HASH_W-1:0]   hash;
  } store_req_t;

endpackage

/* hdl/region_change_detector_fnv1a.sv */
// Region change detector. Bytes of numbered memory regions stream in one word
// per cycle and are folded into a 32-bit FNV-1a hash; bytes of the configured
// skip region whose position lies in [skip_start, skip_end) are left out. The
// word flagged by tlast closes the pass: its tail value is XORed in and one
// result word reports the region, the hash and whether it differs from the
// hash last committed for that region (always set if nothing was committed or
// the region is outside REGION_COUNT). A commit word (tuser high) with send_ok
// set stores that region's last reported hash as committed; commits give no
// result. Each word is held in an input register, the hash step, skip test
// and compare run in the next cycle, and a closing word's result is then
// registered in an output register. The block takes one word per cycle, also
// while a result waits to be taken; it stalls only when a closing word meets
// a full output register that is not being emptied. Configuration is
// meant to be written while the block is idle. The byte position saturates at
// 2^POSITION_BITS - 1.
module region_change_detector_fnv1a #(
  parameter int REGION_COUNT  = rcd_pkg::REGION_COUNT_DEF,
  parameter int POSITION_BITS = rcd_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] region, [11:4] data_byte, [19:12] tail_value, [20] send_ok
  input  logic [rcd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] kind: low for a data byte, high for a commit
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] result_region, [35:4] hash, [36] changed
  output logic [rcd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcd_pkg::CFG_W-1:0]           cfg_wdata
);

  rcd_pkg::cfg_t       cfg_r, cfg_nxt;
  rcd_pkg::item_t      in_item;
  rcd_pkg::item_t      s1_item_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_result;
  logic                advance;
  logic                in_fire;
  rcd_pkg::store_req_t store_req;
  logic                changed;
  logic [rcd_pkg::HASH_W-1:0] hash_final;
  logic                out_valid_r, out_valid_nxt;
  logic [rcd_pkg::OUT_TDATA_W-1:0] out_data_r;

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rcd_pkg::CFG_SKIP_REGION: cfg_nxt.skip_region = cfg_wdata[rcd_pkg::REGION_W-1:0];
        rcd_pkg::CFG_SKIP_START:  cfg_nxt.skip_start  = cfg_wdata;
        rcd_pkg::CFG_SKIP_END:    cfg_nxt.skip_end    = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack the incoming word.
  assign in_item.kind       = in_tuser;
  assign in_item.region     = in_tdata[3:0];
  assign in_item.data_byte  = in_tdata[11:4];
  assign in_item.last       = in_tlast;
  assign in_item.tail_value = in_tdata[19:12];
  assign in_item.send_ok    = in_tdata[20];

  // The held word moves on unless it closes a pass and the result slot is
  // still occupied by a result nobody has taken.
  assign s1_result = s1_valid_r && (s1_item_r.kind == rcd_pkg::KIND_DATA) && s1_item_r.last;
  assign advance   = s1_valid_r && (!s1_result || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  // Running hash and byte position.
  rcd_hash_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .hash_final(hash_final)
  );

  // Pending and committed hashes per region.
  assign store_req.pass_done = advance && s1_result;
  assign store_req.commit    = advance && (s1_item_r.kind == rcd_pkg::KIND_COMMIT)
                               && s1_item_r.send_ok;
  assign store_req.region    = s1_item_r.region;
  assign store_req.hash      = hash_final;

  rcd_region_store #(
    .REGION_COUNT(REGION_COUNT)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (store_req),
    .changed(changed)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (store_req.pass_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_req.pass_done) begin
      out_data_r <= {3'b000, changed, hash_final, s1_item_r.region};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/rcd_hash_core.sv */
module rcd_hash_core #(
  parameter int POSITION_BITS = rcd_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  rcd_pkg::item_t              item,
  input  rcd_pkg::cfg_t               cfg,
  output logic [rcd_pkg::HASH_W-1:0]  hash_final
);

  localparam int CMP_W = (POSITION_BITS > rcd_pkg::CFG_W) ? POSITION_BITS : rcd_pkg::CFG_W;

  logic [rcd_pkg::HASH_W-1:0] run_hash_r, run_hash_nxt;
  logic [POSITION_BITS-1:0]   pos_r, pos_nxt;
  logic [rcd_pkg::HASH_W-1:0] hash_step;
  logic [rcd_pkg::HASH_W-1:0] mixed;
  logic [CMP_W-1:0]           pos_ext, start_ext, end_ext;
  logic                       skipped;
  logic                       is_data;

  assign pos_ext   = CMP_W'(pos_r);
  assign start_ext = CMP_W'(cfg.skip_start);
  assign end_ext   = CMP_W'(cfg.skip_end);

  // An empty or reversed window can never satisfy both compares.
  assign skipped = (item.region == cfg.skip_region) && (pos_ext >= start_ext)
                   && (pos_ext < end_ext);

  assign mixed      = run_hash_r ^ rcd_pkg::HASH_W'(item.data_byte);
  assign hash_step  = skipped ? run_hash_r : mixed * rcd_pkg::FNV_PRIME;
  assign hash_final = hash_step ^ rcd_pkg::HASH_W'(item.tail_value);
  assign is_data    = (item.kind == rcd_pkg::KIND_DATA);

  always_comb begin
    run_hash_nxt = run_hash_r;
    pos_nxt      = pos_r;
    if (fire && is_data) begin
      if (item.last) begin
        run_hash_nxt = rcd_pkg::FNV_BASIS;
        pos_nxt      = '0;
      end else begin
        run_hash_nxt = hash_step;
        // The position sticks at its maximum.
        pos_nxt      = (pos_r == '1) ? pos_r : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_hash_r <= rcd_pkg::FNV_BASIS;
      pos_r      <= '0;
    end else begin
      run_hash_r <= run_hash_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

/* hdl/rcd_region_store.sv */
module rcd_region_store #(
  parameter int REGION_COUNT = rcd_pkg::REGION_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcd_pkg::store_req_t  req,
  output logic                 changed
);

  // Only as many entries as the region field can address.
  localparam int MAX_REG = 1 << rcd_pkg::REGION_W;
  localparam int DEPTH   = (REGION_COUNT < MAX_REG) ? REGION_COUNT : MAX_REG;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [rcd_pkg::HASH_W-1:0] committed_r [DEPTH];
  logic [rcd_pkg::HASH_W-1:0] pending_r   [DEPTH];
  logic [DEPTH-1:0]           valid_r, valid_nxt;
  logic [AW-1:0]              idx;
  logic                       in_range;

  assign in_range = (32'(req.region) < REGION_COUNT);
  assign idx      = AW'(req.region);

  assign changed = !in_range || !valid_r[idx] || (committed_r[idx] != req.hash);

  always_comb begin
    valid_nxt = valid_r;
    if (req.commit && in_range) begin
      valid_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.commit && in_range) begin
      committed_r[idx] <= pending_r[idx];
    end
    if (req.pass_done && in_range) begin
      pending_r[idx] <= req.hash;
    end
  end

endmodule
